### src/ecsp_pkg.sv
// Shared types and constants for the encoder capture speed/position monitor.
package ecsp_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        OP_CAPTURE  = 2'd0,
        OP_OVERFLOW = 2'd1,
        OP_POLL     = 2'd2
    } ecsp_op_t;

    localparam logic CFG_TICKS_PER_OVF = 1'b0;
    localparam logic CFG_TICK_RATE     = 1'b1;

    localparam logic [16:0] TPO_RESET   = 17'd65532;
    localparam logic [31:0] RATE_RESET  = 32'd1663366;
    localparam logic [15:0] PENDING_MAX = 16'hFFFF;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } ecsp_div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DATA_W-1:0] quotient;
    } ecsp_div_rsp_t;

endpackage

### src/ecsp_if.sv
// Handshake interfaces: event requests, poll results and register writes.
interface ecsp_evt_if #(
    parameter int CAPTURE_BITS = 16
);
    logic                    valid;
    logic                    ready;
    logic [1:0]              opcode;
    logic [2:0]              channel;
    logic [CAPTURE_BITS-1:0] capture_time;
    logic                    line_b_level;

    modport source (output valid, opcode, channel, capture_time, line_b_level, input ready);
    modport sink   (input valid, opcode, channel, capture_time, line_b_level, output ready);
endinterface

interface ecsp_res_if;
    logic               valid;
    logic               ready;
    logic [2:0]         polled_channel;
    logic [31:0]        frequency_hz;
    logic [31:0]        total_ticks;
    logic signed [31:0] position;
    logic               direction;
    logic               zero_period;

    modport source (output valid, polled_channel, frequency_hz, total_ticks, position,
                    direction, zero_period, input ready);
    modport sink   (input valid, polled_channel, frequency_hz, total_ticks, position,
                    direction, zero_period, output ready);
endinterface

interface ecsp_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/ecsp_state_mem.sv
// Per-channel state memory: one write port, one registered read port, valid bits.
module ecsp_state_mem #(
    parameter int DEPTH     = 8,
    parameter int DATA_BITS = 64,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DEPTH-1:0]     valid_reg;
    logic [DATA_BITS-1:0] rd_data_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // never-written entries read as the reset value (all zero)
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

### src/ecsp_div.sv
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
module ecsp_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ecsp_pkg::ecsp_div_req_t req,
    output ecsp_pkg::ecsp_div_rsp_t rsp
);

    localparam int W     = ecsp_pkg::DATA_W;
    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     dvs_reg;
    logic [W:0]       shifted;
    logic             fits;
    logic [W:0]       diff;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[W-1:0] : shifted[W-1:0];
            quo_reg <= {quo_reg[W-2:0], fits};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !req.start)
        else $error("divider restarted while busy");
`endif

endmodule

### src/encoder_capture_speed_position.sv
// Encoder capture speed/position monitor: top level with sequencer and registers.
//
// Channels: evt (sink) takes one request per event: capture on a channel,
// shared timebase overflow, or poll of a channel. res (source) returns one
// result per poll of a present channel. cfg (sink) writes ticks_per_overflow
// (index 0) and tick_rate_hz (index 1); it is always ready.
// Sequence: an overflow request is taken in S_IDLE and only bumps the counter.
// A capture reads the channel state at accept and writes it back in S_READ.
// A poll reads the state at accept, writes the position back in S_READ, then
// multiplies (S_MUL), sums (S_SUM), runs the bit-serial divider (S_DIV) and
// loads the result in S_DONE; the next request is taken after S_DONE.
// A poll of zero total ticks skips the divider.
// The serial divider and the single-port state read set how long a poll takes.
// Captures and polls on absent channels, and requests with opcode 3, are dropped.
// Reset: overflow counter and all channel state read as zero, registers
// take their defaults; no clearing pass is needed.
// Stall: a finished result sits in the output register; the block keeps
// taking requests, and only a second poll result waits for the first to go.
module encoder_capture_speed_position #(
    parameter int CHANNELS     = 8,
    parameter int CAPTURE_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    ecsp_evt_if.sink      evt,
    ecsp_res_if.source    res,
    ecsp_cfg_if.sink      cfg
);

    localparam int CH_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // per-channel state word kept in the memory
    typedef struct packed {
        logic [CAPTURE_BITS-1:0] prev_cap;
        logic [CAPTURE_BITS-1:0] last_cap;
        logic [31:0]             prev_stamp;
        logic [31:0]             last_stamp;
        logic [15:0]             pending;
        logic [31:0]             position;
        logic                    line_b;
    } entry_t;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_MUL  = 6'b000100,
        S_SUM  = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    logic [31:0]             ovf_cnt_reg;
    logic [16:0]             tpo_reg;
    logic [31:0]             rate_reg;

    logic [CH_BITS-1:0]      ch_reg;
    logic                    is_poll_reg;
    logic [CAPTURE_BITS-1:0] cap_reg;
    logic                    lb_reg;

    logic [31:0]             stamp_diff_reg;
    logic [31:0]             cap_diff_reg;
    logic [31:0]             prod_reg;
    logic [31:0]             total_reg;
    logic                    zero_reg;
    logic [31:0]             pos_reg;
    logic                    dir_reg;

    logic                    res_valid_reg;
    logic [2:0]              res_ch_reg;
    logic [31:0]             res_freq_reg;
    logic [31:0]             res_total_reg;
    logic [31:0]             res_pos_reg;
    logic                    res_dir_reg;
    logic                    res_zero_reg;

    logic                    evt_fire;
    logic                    evt_present;
    logic                    evt_mem_op;
    logic                    res_free;

    logic [$bits(entry_t)-1:0] rd_word;
    entry_t                  rd_ent;
    entry_t                  wr_ent;
    logic [31:0]             pos_new;
    logic [48:0]             prod_full;
    logic [31:0]             sum;

    ecsp_pkg::ecsp_div_req_t div_req;
    ecsp_pkg::ecsp_div_rsp_t div_rsp;

    // handshakes
    assign evt.ready   = (state_reg == S_IDLE);
    assign evt_fire    = evt.valid && evt.ready;
    assign evt_present = (32'(evt.channel) < CHANNELS);
    assign evt_mem_op  = evt_present && ((evt.opcode == ecsp_pkg::OP_CAPTURE)
                                      || (evt.opcode == ecsp_pkg::OP_POLL));
    assign cfg.ready   = 1'b1;
    assign res_free    = !res_valid_reg || res.ready;

    // channel state memory: read at accept, written back in S_READ
    ecsp_state_mem #(
        .DEPTH     (CHANNELS),
        .DATA_BITS ($bits(entry_t))
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (evt_fire && evt_mem_op),
        .rd_addr (evt.channel[CH_BITS-1:0]),
        .rd_data (rd_word),
        .wr_en   (state_reg == S_READ),
        .wr_addr (ch_reg),
        .wr_data (wr_ent)
    );

    assign rd_ent = entry_t'(rd_word);

    // position folds in pending edges by the sampled direction
    assign pos_new = rd_ent.line_b ? (rd_ent.position + 32'(rd_ent.pending))
                                   : (rd_ent.position - 32'(rd_ent.pending));

    always_comb
    begin
        wr_ent = rd_ent;
        if (is_poll_reg)
        begin
            wr_ent.pending  = '0;
            wr_ent.position = pos_new;
        end
        else
        begin
            wr_ent.prev_cap   = rd_ent.last_cap;
            wr_ent.last_cap   = cap_reg;
            wr_ent.prev_stamp = rd_ent.last_stamp;
            wr_ent.last_stamp = ovf_cnt_reg;
            wr_ent.line_b     = lb_reg;
            if (rd_ent.pending != ecsp_pkg::PENDING_MAX)
            begin
                wr_ent.pending = rd_ent.pending + 16'd1;
            end
        end
    end

    assign prod_full = stamp_diff_reg * tpo_reg;
    assign sum       = prod_reg + cap_diff_reg;

    assign div_req.start    = (state_reg == S_SUM) && (sum != 32'd0);
    assign div_req.dividend = rate_reg;
    assign div_req.divisor  = sum;

    ecsp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (evt_fire && evt_mem_op)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = is_poll_reg ? S_MUL : S_IDLE;
            end
            S_MUL:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = (sum == 32'd0) ? S_DONE : S_DIV;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ovf_cnt_reg   <= '0;
            tpo_reg       <= ecsp_pkg::TPO_RESET;
            rate_reg      <= ecsp_pkg::RATE_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (evt_fire && (evt.opcode == ecsp_pkg::OP_OVERFLOW))
            begin
                ovf_cnt_reg <= ovf_cnt_reg + 32'd1;
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    ecsp_pkg::CFG_TICKS_PER_OVF: tpo_reg  <= cfg.data[16:0];
                    ecsp_pkg::CFG_TICK_RATE:     rate_reg <= cfg.data;
                    default:                     rate_reg <= rate_reg;
                endcase
            end
            if ((state_reg == S_DONE) && res_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (evt_fire)
        begin
            ch_reg      <= evt.channel[CH_BITS-1:0];
            is_poll_reg <= (evt.opcode == ecsp_pkg::OP_POLL);
            cap_reg     <= evt.capture_time;
            lb_reg      <= evt.line_b_level;
        end
        if (state_reg == S_READ)
        begin
            stamp_diff_reg <= rd_ent.last_stamp - rd_ent.prev_stamp;
            cap_diff_reg   <= 32'(rd_ent.last_cap) - 32'(rd_ent.prev_cap);
            pos_reg        <= pos_new;
            dir_reg        <= rd_ent.line_b;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= prod_full[31:0];
        end
        if (state_reg == S_SUM)
        begin
            total_reg <= sum;
            zero_reg  <= (sum == 32'd0);
        end
        if ((state_reg == S_DONE) && res_free)
        begin
            res_ch_reg    <= 3'(ch_reg);
            res_freq_reg  <= zero_reg ? 32'd0 : div_rsp.quotient;
            res_total_reg <= total_reg;
            res_pos_reg   <= pos_reg;
            res_dir_reg   <= dir_reg;
            res_zero_reg  <= zero_reg;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.polled_channel = res_ch_reg;
    assign res.frequency_hz   = res_freq_reg;
    assign res.total_ticks    = res_total_reg;
    assign res.position       = $signed(res_pos_reg);
    assign res.direction      = res_dir_reg;
    assign res.zero_period    = res_zero_reg;

`ifndef SYNTHESIS
    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        evt.ready |-> !div_rsp.busy)
        else $error("request taken while a division runs");
    a_zero_freq: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_zero_reg) |-> (res_freq_reg == 32'd0))
        else $error("zero period with nonzero frequency");
    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_zero_reg == (res_total_reg == 32'd0)))
        else $error("zero period flag disagrees with total ticks");
    a_ovf_count: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_fire && (evt.opcode == ecsp_pkg::OP_OVERFLOW))
        |=> (ovf_cnt_reg == $past(ovf_cnt_reg) + 32'd1))
        else $error("overflow counter missed an increment");
`endif

endmodule
